### rtl/core/doubly_linked_free_list_assert.svh
// Assertion macros for the doubly linked free list RTL.
// Sampled on clk, disabled while arst_n is low; empty when SYNTHESIS is set.
`ifndef DOUBLY_LINKED_FREE_LIST_ASSERT_SVH
`define DOUBLY_LINKED_FREE_LIST_ASSERT_SVH

`ifndef SYNTHESIS
`define DLFL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dlfl assertion failed");
`define DLFL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dlfl assertion failed");
`else
`define DLFL_ASSERT_IMP(lbl, ante, cons)
`define DLFL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/core/dlfl_pkg.sv
// Shared types and constants of the doubly linked free list.
// No dependencies.
`default_nettype none

package dlfl_pkg;

	localparam int POOL_NODES_DEF = 256;
	localparam int NODE_W         = 8;
	localparam int FUNC_W         = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH   = 2'd0,
		FUNC_POP    = 2'd1,
		FUNC_REMOVE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_PUSH,
		OP_POP,
		OP_REMOVE
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_LINK
	} state_t;

endpackage

`default_nettype wire

### rtl/core/dlfl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module dlfl_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/doubly_linked_free_list.sv
// Top level of the doubly linked free list: head register, link sequencer.
// Depends on dlfl_pkg, dlfl_ram and doubly_linked_free_list_assert.svh.
//
// Usage:
//   A word (func, node_index) is taken at a rising edge with start high and
//   busy low. func 0 pushes node_index at the front, 1 pops the front node,
//   2 unlinks node_index from wherever it sits; other codes change nothing.
//   In the accept cycle reads of the next and prev link memories are issued
//   (and the push link writes); in state ST_LINK the read data is used to
//   patch neighbors and the head. busy is high in ST_LINK, so no new word
//   is taken while the word in flight is in that state.
//   The result word (popped_node, status, list_empty) is on its ports for
//   exactly one cycle with done high, which is registered from ST_LINK;
//   the next word may be taken in that same cycle. The receiver cannot
//   stall and must take each result when done is high.
//   Reset makes the list empty at once; link memories are not cleared and
//   become defined as nodes are pushed.
`default_nettype none

`include "doubly_linked_free_list_assert.svh"

module doubly_linked_free_list #(
	parameter int POOL_NODES = dlfl_pkg::POOL_NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [dlfl_pkg::FUNC_W-1:0] func,
	input  logic [dlfl_pkg::NODE_W-1:0] node_index,
	output logic                        done,
	output logic [dlfl_pkg::NODE_W-1:0] popped_node,
	output logic                        status,
	output logic                        list_empty
);

	import dlfl_pkg::*;

	localparam int LINK_W = $clog2(POOL_NODES + 2);
	localparam int ADDR_W = $clog2(POOL_NODES);
	localparam logic [LINK_W-1:0] NONE_CODE = LINK_W'(POOL_NODES);
	localparam logic [LINK_W-1:0] HEAD_CODE = LINK_W'(POOL_NODES + 1);

	state_t state_q, state_d;
	logic [LINK_W-1:0] head_q, head_d;

	op_t               op_s1;
	logic [LINK_W-1:0] node_s1;
	logic [LINK_W-1:0] head_s1;

	logic              done_q;
	logic [NODE_W-1:0] popped_q, popped_d;
	logic              status_q, status_d;
	logic              empty_q;

	logic              accept;
	logic              node_ok;
	logic [LINK_W-1:0] node_l;
	op_t               op_a;

	logic              nx_we, nx_re;
	logic [ADDR_W-1:0] nx_waddr, nx_raddr;
	logic [LINK_W-1:0] nx_wdata, nx_rdata;
	logic              pv_we, pv_re;
	logic [ADDR_W-1:0] pv_waddr, pv_raddr;
	logic [LINK_W-1:0] pv_wdata, pv_rdata;

	assign accept  = start && (state_q == ST_IDLE);
	assign node_l  = LINK_W'(node_index);
	assign node_ok = 32'(node_index) < 32'(POOL_NODES);

	always_comb begin
		case (func)
			FUNC_PUSH:   op_a = node_ok ? OP_PUSH : OP_NOP;
			FUNC_POP:    op_a = OP_POP;
			FUNC_REMOVE: op_a = node_ok ? OP_REMOVE : OP_NOP;
			default:     op_a = OP_NOP;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		popped_d = '0;
		status_d = 1'b0;
		nx_we    = 1'b0;
		nx_waddr = node_l[ADDR_W-1:0];
		nx_wdata = head_q;
		nx_re    = accept;
		nx_raddr = (op_a == OP_POP) ? head_q[ADDR_W-1:0] : node_l[ADDR_W-1:0];
		pv_we    = 1'b0;
		pv_waddr = node_l[ADDR_W-1:0];
		pv_wdata = HEAD_CODE;
		pv_re    = accept;
		pv_raddr = node_l[ADDR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LINK;
					if (op_a == OP_PUSH) begin
						nx_we  = 1'b1;
						pv_we  = 1'b1;
						head_d = node_l;
					end
				end
			end
			ST_LINK: begin
				state_d = ST_IDLE;
				case (op_s1)
					OP_PUSH: begin
						pv_we    = head_s1 < NONE_CODE;
						pv_waddr = head_s1[ADDR_W-1:0];
						pv_wdata = node_s1;
					end
					OP_POP: begin
						if (head_q >= NONE_CODE) begin
							status_d = 1'b1;
						end else begin
							popped_d = NODE_W'(head_q);
							if (nx_rdata == NONE_CODE) begin
								head_d = NONE_CODE;
							end else begin
								pv_we    = nx_rdata < NONE_CODE;
								pv_waddr = nx_rdata[ADDR_W-1:0];
								pv_wdata = HEAD_CODE;
								head_d   = nx_rdata;
							end
						end
					end
					OP_REMOVE: begin
						if (pv_rdata == HEAD_CODE) begin
							head_d = nx_rdata;
						end else begin
							nx_we    = pv_rdata < NONE_CODE;
							nx_waddr = pv_rdata[ADDR_W-1:0];
							nx_wdata = nx_rdata;
						end
						pv_we    = nx_rdata < NONE_CODE;
						pv_waddr = nx_rdata[ADDR_W-1:0];
						pv_wdata = pv_rdata;
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= NONE_CODE;
			done_q  <= 1'b0;
			op_s1   <= OP_NOP;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			done_q  <= (state_q == ST_LINK);
			if (accept) begin
				op_s1 <= op_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			node_s1 <= node_l;
			head_s1 <= head_q;
		end
		if (state_q == ST_LINK) begin
			popped_q <= popped_d;
			status_q <= status_d;
			empty_q  <= head_d >= NONE_CODE;
		end
	end

	dlfl_ram #(
		.WIDTH (LINK_W),
		.DEPTH (POOL_NODES)
	) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.re    (nx_re),
		.raddr (nx_raddr),
		.rdata (nx_rdata)
	);

	dlfl_ram #(
		.WIDTH (LINK_W),
		.DEPTH (POOL_NODES)
	) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.re    (pv_re),
		.raddr (pv_raddr),
		.rdata (pv_rdata)
	);

	assign busy        = (state_q == ST_LINK);
	assign done        = done_q;
	assign popped_node = popped_q;
	assign status      = status_q;
	assign list_empty  = empty_q;

	`DLFL_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`DLFL_ASSERT_NXT(a_link_done, busy, done && !busy)
	`DLFL_ASSERT_IMP(a_done_idle, done, !busy)
	`DLFL_ASSERT_IMP(a_empty_pop, done && status, list_empty && (popped_node == '0))

endmodule

`default_nettype wire
